FILE: src/klock_pkg.sv
// ----------------------------------------------------------------------------
// klock_pkg
// Shared types and constants of the keypad code lock.
// ----------------------------------------------------------------------------
package klock_pkg;

    // Field widths of the streams and the configuration register.
    localparam int KEY_W    = 8;
    localparam int STATUS_W = 3;
    localparam int LEN_W    = 5;

    // Reset value of the confirm key register (the '#' character).
    localparam logic [KEY_W-1:0] CONFIRM_KEY_RESET = 8'd35;

    // Event kinds carried on the input side.
    typedef enum logic {
        OP_KEY     = 1'b0,
        OP_TIMEOUT = 1'b1
    } opcode_t;

    // Result codes reported for every event.
    typedef enum logic [STATUS_W-1:0] {
        ST_STORED  = 3'd0,
        ST_OPEN    = 3'd1,
        ST_WRONG   = 3'd2,
        ST_UPDATED = 3'd3,
        ST_TIMEOUT = 3'd4,
        ST_FULL    = 3'd5,
        ST_RESTART = 3'd6,
        ST_IGNORED = 3'd7
    } status_t;

    // One result item as it travels from the lock core to the output stage.
    typedef struct packed {
        logic              in_setup;
        logic [LEN_W-1:0]  entry_length;
        status_t           status;
    } result_t;

endpackage

FILE: src/klock_core.sv
// ----------------------------------------------------------------------------
// klock_core
// Lock state, entry and stored code buffers, and the single-pass event logic.
// ----------------------------------------------------------------------------
module klock_core #(
    parameter int MAX_CODE_LEN = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          item_valid,
    input  klock_pkg::opcode_t            opcode,
    input  logic [klock_pkg::KEY_W-1:0]   key_code,
    input  logic [klock_pkg::KEY_W-1:0]   confirm_key,
    output klock_pkg::result_t            result
);

    localparam int CNT_W = $clog2(MAX_CODE_LEN + 1);
    localparam int IDX_W = (MAX_CODE_LEN > 1) ? $clog2(MAX_CODE_LEN) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CODE_LEN);

    typedef enum logic [1:0] {
        MODE_NORMAL        = 2'd0,
        MODE_SETUP_FIRST   = 2'd1,
        MODE_SETUP_COLLECT = 2'd2,
        MODE_SETUP_CONFIRM = 2'd3
    } mode_t;

    mode_t                       mode_reg, mode_next;
    logic [CNT_W-1:0]            entry_count_reg, entry_count_next;
    logic [CNT_W-1:0]            stored_count_reg, stored_count_next;
    logic [klock_pkg::KEY_W-1:0] entered_code_reg [MAX_CODE_LEN];
    logic [klock_pkg::KEY_W-1:0] stored_code_reg  [MAX_CODE_LEN];

    klock_pkg::status_t          status;
    logic                        is_confirm;
    logic                        is_full;
    logic                        mismatch;
    logic                        codes_match;
    logic                        do_append;
    logic                        do_commit;
    logic [31:0]                 count_ext;

    assign is_confirm = (key_code == confirm_key);
    assign is_full    = (entry_count_reg >= CNT_MAX);

    // Parallel compare of the live part of both buffers.
    always_comb begin
        mismatch = 1'b0;
        for (int i = 0; i < MAX_CODE_LEN; i++) begin
            if ((CNT_W'(i) < entry_count_reg) && (entered_code_reg[i] != stored_code_reg[i])) begin
                mismatch = 1'b1;
            end
        end
        codes_match = (entry_count_reg == stored_count_reg) && !mismatch;
    end

    // Event decode: next mode, next counts and the status code.
    always_comb begin
        mode_next         = mode_reg;
        entry_count_next  = entry_count_reg;
        stored_count_next = stored_count_reg;
        status            = klock_pkg::ST_IGNORED;
        do_append         = 1'b0;
        do_commit         = 1'b0;
        if (opcode == klock_pkg::OP_TIMEOUT) begin
            if (mode_reg == MODE_NORMAL) begin
                entry_count_next = '0;
                status           = klock_pkg::ST_TIMEOUT;
            end
        end else begin
            case (mode_reg)
                MODE_NORMAL: begin
                    if (is_confirm) begin
                        status           = codes_match ? klock_pkg::ST_OPEN
                                                       : klock_pkg::ST_WRONG;
                        entry_count_next = '0;
                    end else if (is_full) begin
                        status = klock_pkg::ST_FULL;
                    end else begin
                        do_append        = 1'b1;
                        entry_count_next = entry_count_reg + 1'b1;
                        status           = klock_pkg::ST_STORED;
                    end
                end
                MODE_SETUP_FIRST: begin
                    entry_count_next = '0;
                    mode_next        = MODE_SETUP_COLLECT;
                end
                MODE_SETUP_COLLECT: begin
                    if (is_confirm) begin
                        mode_next = MODE_SETUP_CONFIRM;
                        status    = klock_pkg::ST_STORED;
                    end else if (is_full) begin
                        status = klock_pkg::ST_FULL;
                    end else begin
                        do_append        = 1'b1;
                        entry_count_next = entry_count_reg + 1'b1;
                        status           = klock_pkg::ST_STORED;
                    end
                end
                default: begin
                    entry_count_next = '0;
                    if (is_confirm) begin
                        do_commit         = 1'b1;
                        stored_count_next = entry_count_reg;
                        mode_next         = MODE_NORMAL;
                        status            = klock_pkg::ST_UPDATED;
                    end else begin
                        mode_next = MODE_SETUP_COLLECT;
                        status    = klock_pkg::ST_RESTART;
                    end
                end
            endcase
        end
    end

    // Result of the current event; the length is reported modulo 32.
    assign count_ext           = 32'(entry_count_next);
    assign result.status       = status;
    assign result.entry_length = count_ext[klock_pkg::LEN_W-1:0];
    assign result.in_setup     = (mode_next != MODE_NORMAL);

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= MODE_SETUP_FIRST;
            entry_count_reg  <= '0;
            stored_count_reg <= '0;
        end else if (item_valid) begin
            mode_reg         <= mode_next;
            entry_count_reg  <= entry_count_next;
            stored_count_reg <= stored_count_next;
        end
    end

    // Code buffers: append one key, or copy the whole entry on commit.
    always_ff @(posedge aclk) begin
        if (item_valid && do_append) begin
            entered_code_reg[entry_count_reg[IDX_W-1:0]] <= key_code;
        end
        if (item_valid && do_commit) begin
            for (int i = 0; i < MAX_CODE_LEN; i++) begin
                stored_code_reg[i] <= entered_code_reg[i];
            end
        end
    end

endmodule

FILE: src/klock_out.sv
// ----------------------------------------------------------------------------
// klock_out
// Result register with a skid stage on the master stream side.
// ----------------------------------------------------------------------------
module klock_out (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    output logic               push_ready,
    input  klock_pkg::result_t push_data,
    output logic               out_valid,
    input  logic               out_ready,
    output klock_pkg::result_t out_data,
    output logic               skid_busy
);

    logic               out_valid_reg;
    klock_pkg::result_t out_data_reg;
    logic               skid_valid_reg;
    klock_pkg::result_t skid_data_reg;
    logic               push;
    logic               out_free;

    assign push_ready = !skid_valid_reg;
    assign push       = push_valid && push_ready;
    assign out_free   = !out_valid_reg || out_ready;

    // The result register refills from the skid stage first, then from a new transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end else if (push) begin
            skid_data_reg <= push_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign skid_busy = skid_valid_reg;

endmodule

FILE: src/keypad_code_lock_unit.sv
// A result is held in the result register, or in the skid stage while stalled.
// Throughput: one event per cycle while the skid stage is empty (single-pass lock logic).
// A skid stage lets one more transaction in while a result waits for m_tready.
// Reset (aresetn low, synchronous) enters setup mode awaiting the first key, clears
// both counts and the output stage, and sets the confirm key to '#'.
// ----------------------------------------------------------------------------
// keypad_code_lock_unit
// Combination lock driven by key presses and inactivity timeout ticks, with
// an APB-style register for the confirm key.
// ----------------------------------------------------------------------------
module keypad_code_lock_unit #(
    parameter int MAX_CODE_LEN = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] key_code
    input  logic [0:0]  s_tuser,   // [0] opcode
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [2:0] status, [7:3] entry_length, [8] in_setup
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic ADDR_CONFIRM_KEY = 1'b0;

    logic [klock_pkg::KEY_W-1:0] confirm_key_reg;
    logic                        cfg_write;
    logic                        item_valid;
    logic                        core_ready;
    logic                        skid_busy;
    klock_pkg::result_t          core_result;
    klock_pkg::result_t          out_result;

    // Configuration register access.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            confirm_key_reg <= klock_pkg::CONFIRM_KEY_RESET;
        end else if (cfg_write && (paddr[2] == ADDR_CONFIRM_KEY)) begin
            confirm_key_reg <= pwdata[klock_pkg::KEY_W-1:0];
        end
    end

    assign prdata = (paddr[2] == ADDR_CONFIRM_KEY) ? 32'(confirm_key_reg) : 32'd0;

    // Input transaction.
    assign s_tready   = core_ready;
    assign item_valid = s_tvalid && s_tready;

    klock_core #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_valid  (item_valid),
        .opcode      (klock_pkg::opcode_t'(s_tuser[0])),
        .key_code    (s_tdata[klock_pkg::KEY_W-1:0]),
        .confirm_key (confirm_key_reg),
        .result      (core_result)
    );

    klock_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_tvalid),
        .push_ready (core_ready),
        .push_data  (core_result),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_result),
        .skid_busy  (skid_busy)
    );

    assign m_tdata = {7'd0, out_result.in_setup, out_result.entry_length, out_result.status};

`ifndef SYNTH
    // The skid stage only holds a result while the result register is full.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_busy |-> m_tvalid)
        else $error("skid stage valid while result register empty");

    // A stalled result with a full skid stage blocks the input side.
    a_full_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready && skid_busy) |-> !s_tready)
        else $error("input accepted with both output stages full");

    // A committed code leaves setup mode with an empty entry.
    a_commit_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid && (core_result.status == klock_pkg::ST_UPDATED))
            |-> (!core_result.in_setup && (core_result.entry_length == '0)))
        else $error("code update did not return to normal mode");

    // Compare and timeout results always clear the entry in normal mode.
    a_clear_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid && ((core_result.status == klock_pkg::ST_OPEN)
                     || (core_result.status == klock_pkg::ST_WRONG)
                     || (core_result.status == klock_pkg::ST_TIMEOUT)))
            |-> (!core_result.in_setup && (core_result.entry_length == '0)))
        else $error("compare or timeout left a non-empty entry");
`endif

endmodule

FILE: bench/keypad_code_lock_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_code_lock_unit_tb
// Self-checking bench for the keypad code lock. Directed sequences walk the
// setup flow, the code commit and normal-mode unlocking. Random sequences then
// run under several confirm key settings. A behavioral lock model predicts
// every result, and a monitor compares each result transaction field by field.
// ----------------------------------------------------------------------------
module keypad_code_lock_unit_tb;

    localparam int CODE_DEPTH = 16;
    localparam logic [2:0] REG_CONFIRM_KEY = 3'd0;

    // Lock modes tracked by the bench's own model.
    typedef enum logic [1:0] {
        LK_NORMAL        = 2'd0,
        LK_SETUP_FIRST   = 2'd1,
        LK_SETUP_COLLECT = 2'd2,
        LK_SETUP_CONFIRM = 2'd3
    } lock_mode_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] key_code
    logic [0:0]  s_tuser;   // [0] opcode
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [2:0] status, [7:3] entry_length, [8] in_setup
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Model state: entry buffer, saved code, mode and confirm key.
    logic [7:0]  entry_keys [CODE_DEPTH];
    logic [7:0]  saved_keys [CODE_DEPTH];
    int unsigned entry_len;
    int unsigned saved_len;
    lock_mode_t  lock_state;
    logic [7:0]  confirm_code;

    // Results still owed by the lock, oldest first.
    klock_pkg::result_t pending_results [$];
    klock_pkg::result_t want;

    int unsigned errors;
    int unsigned events_sent;
    int unsigned burst_left;
    int unsigned key_settings;
    int unsigned n_open, n_wrong, n_timeout, n_full, n_restart;

    keypad_code_lock_unit #(
        .MAX_CODE_LEN (CODE_DEPTH)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Append one key to the model's entry buffer, dropping it when full.
    function automatic klock_pkg::status_t buffer_key(input logic [7:0] key);
        if (entry_len >= CODE_DEPTH)
            return klock_pkg::ST_FULL;
        entry_keys[entry_len] = key;
        entry_len++;
        return klock_pkg::ST_STORED;
    endfunction

    // Advance the lock model by one event and return the result it reports.
    function automatic klock_pkg::result_t lock_advance(input klock_pkg::opcode_t op,
                                                        input logic [7:0] key);
        klock_pkg::result_t r;
        klock_pkg::status_t st;
        logic               same;
        int unsigned        i;
        st = klock_pkg::ST_IGNORED;
        if (op == klock_pkg::OP_TIMEOUT) begin
            if (lock_state == LK_NORMAL) begin
                entry_len = 0;
                st = klock_pkg::ST_TIMEOUT;
            end
        end else begin
            case (lock_state)
                LK_NORMAL: begin
                    if (key == confirm_code) begin
                        same = (entry_len == saved_len);
                        for (i = 0; i < entry_len; i++)
                            if (entry_keys[i] != saved_keys[i])
                                same = 1'b0;
                        st = same ? klock_pkg::ST_OPEN : klock_pkg::ST_WRONG;
                        entry_len = 0;
                    end else begin
                        st = buffer_key(key);
                    end
                end
                LK_SETUP_FIRST: begin
                    entry_len = 0;
                    lock_state = LK_SETUP_COLLECT;
                end
                LK_SETUP_COLLECT: begin
                    if (key == confirm_code) begin
                        lock_state = LK_SETUP_CONFIRM;
                        st = klock_pkg::ST_STORED;
                    end else begin
                        st = buffer_key(key);
                    end
                end
                default: begin
                    if (key == confirm_code) begin
                        for (i = 0; i < CODE_DEPTH; i++)
                            saved_keys[i] = entry_keys[i];
                        saved_len = entry_len;
                        entry_len = 0;
                        lock_state = LK_NORMAL;
                        st = klock_pkg::ST_UPDATED;
                    end else begin
                        entry_len = 0;
                        lock_state = LK_SETUP_COLLECT;
                        st = klock_pkg::ST_RESTART;
                    end
                end
            endcase
        end
        r.status = st;
        r.entry_length = entry_len[klock_pkg::LEN_W-1:0];
        r.in_setup = (lock_state != LK_NORMAL);
        return r;
    endfunction

    // Random key code that is not the current confirm key.
    function automatic logic [7:0] plain_key();
        logic [7:0] k;
        k = 8'($urandom);
        if (k == confirm_code)
            k = k ^ 8'h01;
        return k;
    endfunction

    // Send one event, record its prediction, then apply the burst pacing.
    task automatic send_event(input klock_pkg::opcode_t op, input logic [7:0] key);
        int unsigned gap;
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = key;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(lock_advance(op, key));
        events_sent++;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 160)
                                                     : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
            end
        end else begin
            burst_left--;
        end
    endtask

    // Stop sending and wait until every owed result has been received.
    task automatic settle_lock();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // Write the confirm key register; only called while the lock is idle.
    task automatic write_confirm_key(input logic [7:0] value);
        settle_lock();
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = REG_CONFIRM_KEY;
        pwdata  = {24'd0, value};
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        confirm_code = value;
        key_settings++;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Setup mode from reset: first key, collection, confirm wait and restart.
    task automatic test_setup_directed();
        send_event(klock_pkg::OP_TIMEOUT, 8'hFF);
        send_event(klock_pkg::OP_KEY, confirm_code);
        send_event(klock_pkg::OP_KEY, 8'hFF);
        send_event(klock_pkg::OP_KEY, 8'h00);
        send_event(klock_pkg::OP_TIMEOUT, 8'h00);
        send_event(klock_pkg::OP_KEY, confirm_code);
        send_event(klock_pkg::OP_TIMEOUT, 8'h5A);
        send_event(klock_pkg::OP_KEY, 8'h41);
        send_event(klock_pkg::OP_KEY, confirm_code);
        send_event(klock_pkg::OP_KEY, 8'hA5);
    endtask

    // Random setup sequences that always end in a restart, never a commit.
    task automatic test_setup_random(input logic [7:0] key, input int unsigned count);
        int unsigned stop_at, n, i;
        write_confirm_key(key);
        stop_at = events_sent + count;
        while (events_sent < stop_at) begin
            n = $urandom_range(0, 18);
            for (i = 0; i < n; i++) begin
                if ($urandom_range(0, 7) == 0)
                    send_event(klock_pkg::OP_TIMEOUT, 8'($urandom));
                send_event(klock_pkg::OP_KEY, plain_key());
            end
            send_event(klock_pkg::OP_KEY, confirm_code);
            if ($urandom_range(0, 2) == 0)
                send_event(klock_pkg::OP_TIMEOUT, 8'($urandom));
            send_event(klock_pkg::OP_KEY, plain_key());
        end
    endtask

    // Collect a five-key code and commit it with a second confirm key.
    task automatic test_commit_code();
        write_confirm_key(klock_pkg::CONFIRM_KEY_RESET);
        send_event(klock_pkg::OP_KEY, 8'h00);
        send_event(klock_pkg::OP_KEY, 8'hFF);
        send_event(klock_pkg::OP_KEY, 8'h5A);
        send_event(klock_pkg::OP_KEY, 8'hA5);
        send_event(klock_pkg::OP_KEY, 8'h31);
        send_event(klock_pkg::OP_KEY, confirm_code);
        send_event(klock_pkg::OP_KEY, confirm_code);
    endtask

    // Normal mode: empty timeout, correct code, partial entry, bare confirm.
    task automatic test_normal_directed();
        int unsigned i;
        send_event(klock_pkg::OP_TIMEOUT, 8'h00);
        for (i = 0; i < saved_len; i++)
            send_event(klock_pkg::OP_KEY, saved_keys[i]);
        send_event(klock_pkg::OP_KEY, confirm_code);
        send_event(klock_pkg::OP_KEY, 8'h00);
        send_event(klock_pkg::OP_KEY, 8'hFF);
        send_event(klock_pkg::OP_TIMEOUT, 8'hFF);
        send_event(klock_pkg::OP_KEY, confirm_code);
    endtask

    // Random unlock attempts: exact code, near misses, long entries, noise.
    task automatic test_normal_random(input logic [7:0] key, input int unsigned count);
        logic [7:0]  guess [CODE_DEPTH + 4];
        int unsigned stop_at, n, i, pick, pos;
        write_confirm_key(key);
        stop_at = events_sent + count;
        while (events_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            n = saved_len;
            for (i = 0; i < saved_len; i++)
                guess[i] = saved_keys[i];
            if (pick < 35) begin
                // Stored code as is.
            end else if (pick < 55) begin
                // Near miss: one key changed, a shorter prefix, or extra keys.
                case ($urandom_range(0, 2))
                    0: begin
                        pos = $urandom_range(0, n - 1);
                        guess[pos] = plain_key();
                    end
                    1: n = $urandom_range(0, n - 1);
                    default: begin
                        for (i = 0; i < $urandom_range(1, 3); i++) begin
                            guess[n] = plain_key();
                            n++;
                        end
                    end
                endcase
            end else if (pick < 80) begin
                // Random length entry; past sixteen keys the buffer is full.
                n = $urandom_range(0, 18);
                for (i = 0; i < n; i++)
                    guess[i] = plain_key();
            end
            if (pick < 92) begin
                for (i = 0; i < n; i++)
                    send_event(klock_pkg::OP_KEY, guess[i]);
                if (pick >= 70 && pick < 80)
                    send_event(klock_pkg::OP_TIMEOUT, 8'($urandom));
                else
                    send_event(klock_pkg::OP_KEY, confirm_code);
            end else begin
                for (i = 0; i < $urandom_range(1, 4); i++)
                    send_event(klock_pkg::opcode_t'($urandom_range(0, 1)), 8'($urandom));
            end
            // Now and then the sender holds off until the lock has caught up.
            if ($urandom_range(0, 49) == 0)
                settle_lock();
        end
    endtask

    // Result sink: stalls follow a rotating pattern that changes now and then.
    initial begin : result_sink
        logic [7:0]  pattern;
        int unsigned hold;
        pattern  = 8'hFF;
        hold     = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold == 0) begin
                hold = $urandom_range(16, 96);
                case ($urandom_range(0, 3))
                    0:       pattern = 8'hFF;
                    1:       pattern = 8'($urandom);
                    2:       pattern = 8'b1000_0001;
                    default: pattern = 8'($urandom) | 8'h11;
                endcase
            end
            hold--;
            m_tready = pattern[0];
            pattern  = {pattern[0], pattern[7:1]};
        end
    end

    // Result monitor: compare every result transaction with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[2:0] !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, m_tdata[2:0]);
                    errors++;
                end
                if (m_tdata[7:3] !== want.entry_length) begin
                    $display("%0t: entry_length mismatch, expected %0d, actual %0d",
                             $time, want.entry_length, m_tdata[7:3]);
                    errors++;
                end
                if (m_tdata[8] !== want.in_setup) begin
                    $display("%0t: in_setup mismatch, expected %0b, actual %0b",
                             $time, want.in_setup, m_tdata[8]);
                    errors++;
                end
                if (m_tdata[15:9] !== 7'd0) begin
                    $display("%0t: padding mismatch, expected 0, actual %h",
                             $time, m_tdata[15:9]);
                    errors++;
                end
                case (want.status)
                    klock_pkg::ST_OPEN:    n_open++;
                    klock_pkg::ST_WRONG:   n_wrong++;
                    klock_pkg::ST_TIMEOUT: n_timeout++;
                    klock_pkg::ST_FULL:    n_full++;
                    klock_pkg::ST_RESTART: n_restart++;
                    default: ;
                endcase
            end
        end
    end

    // Watchdog for a hung handshake.
    initial begin
        #10_000_000;
        $display("Timeout waiting for the lock to finish");
        $display("Simulation FAILED");
        $finish;
    end

    // Main sequence.
    initial begin
        int unsigned i;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'd0;
        s_tuser  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = 3'd0;
        pwdata   = 32'd0;
        for (i = 0; i < CODE_DEPTH; i++) begin
            entry_keys[i] = 8'd0;
            saved_keys[i] = 8'd0;
        end
        entry_len    = 0;
        saved_len    = 0;
        lock_state   = LK_SETUP_FIRST;
        confirm_code = klock_pkg::CONFIRM_KEY_RESET;
        errors       = 0;
        events_sent  = 0;
        burst_left   = 0;
        key_settings = 0;
        n_open = 0; n_wrong = 0; n_timeout = 0; n_full = 0; n_restart = 0;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_setup_directed();
        test_setup_random(8'h00, 150);
        test_setup_random(8'hFF, 150);
        test_commit_code();
        test_normal_directed();
        test_normal_random(klock_pkg::CONFIRM_KEY_RESET, 270);
        test_normal_random(8'h00, 270);
        test_normal_random(8'hFF, 270);
        test_normal_random(8'($urandom), 270);
        test_normal_random(8'($urandom), 270);
        test_normal_random(klock_pkg::CONFIRM_KEY_RESET, 270);
        settle_lock();

        $display("Ran %0d events through setup and normal mode under %0d confirm key settings.",
                 events_sent, key_settings);
        $display("Seen: %0d opened, %0d wrong, %0d timeouts, %0d keys dropped, %0d restarts.",
                 n_open, n_wrong, n_timeout, n_full, n_restart);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
